>>> sv/dcpm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the diatonic chord pad mapper.
// No dependencies; imported by all files but the two channel interfaces.
package dcpm_pkg;

  localparam int REG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 4;

  localparam logic [REG_INDEX_W-1:0] REG_ROOT_KEY        = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_SCALE_MODE      = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SECOND_INTERVAL = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_THIRD_INTERVAL  = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_START_OCTAVE    = 3'd4;

  localparam logic [3:0] STATUS_NOTE_ON = 4'h9;
  localparam logic [3:0] STATUS_CC      = 4'hB;
  localparam logic [6:0] PAD_LOW        = 7'd68;
  localparam logic [6:0] PAD_HIGH       = 7'd99;
  localparam logic [6:0] CC_OCT_UP      = 7'd55;
  localparam logic [6:0] CC_OCT_DOWN    = 7'd54;
  localparam logic [3:0] ROOT_MAX       = 4'd11;

  localparam logic signed [9:0] MIDDLE_NOTE = 10'sd60;
  localparam logic signed [9:0] SEMIS_OCT   = 10'sd12;
  localparam logic signed [9:0] NOTE_MAX    = 10'sd127;
  localparam logic signed [3:0] OCT_MIN     = -4'sd5;
  localparam logic signed [3:0] OCT_MAX     = 4'sd5;

  localparam logic [3:0] MAJOR_STEPS [7] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};
  localparam logic [3:0] MINOR_STEPS [7] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10};

  typedef enum logic [1:0] {
    SCALE_MAJOR     = 2'd0,
    SCALE_MINOR     = 2'd1,
    SCALE_CHROMATIC = 2'd2
  } scale_t;

  typedef enum logic [1:0] {
    KIND_IGNORED = 2'd0,
    KIND_NOTE    = 2'd1,
    KIND_OCTAVE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [3:0]        root_key;
    scale_t            scale_mode;
    logic [3:0]        second_interval;
    logic [3:0]        third_interval;
    logic              oct_load;
    logic signed [3:0] oct_value;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] status_byte;
    logic [6:0] key_or_control;
    logic [6:0] velocity_or_value;
    logic [3:0] midi_channel;
  } midi_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [6:0]        note_number;
    logic [6:0]        note_velocity;
    logic [3:0]        out_channel;
    logic signed [3:0] octave_now;
    logic              last;
  } result_t;

  typedef struct packed {
    result_t [2:0] res;
    logic [1:0]    cnt;
  } run_t;

  // Pad numbers run 0..31, so the quotient by seven is at most four.
  function automatic logic [2:0] pad_div7(input logic [4:0] pad);
    logic [2:0] q;
    if (pad >= 5'd28) begin
      q = 3'd4;
    end else if (pad >= 5'd21) begin
      q = 3'd3;
    end else if (pad >= 5'd14) begin
      q = 3'd2;
    end else if (pad >= 5'd7) begin
      q = 3'd1;
    end else begin
      q = 3'd0;
    end
    return q;
  endfunction

  // Scale indexes run 0..21, so the quotient by seven is at most three.
  function automatic logic [5:0] degree_semis(input scale_t mode, input logic [4:0] idx);
    logic [1:0] q;
    logic [2:0] rem;
    logic [5:0] step;
    if (idx >= 5'd21) begin
      q = 2'd3;
      rem = 3'(idx - 5'd21);
    end else if (idx >= 5'd14) begin
      q = 2'd2;
      rem = 3'(idx - 5'd14);
    end else if (idx >= 5'd7) begin
      q = 2'd1;
      rem = 3'(idx - 5'd7);
    end else begin
      q = 2'd0;
      rem = idx[2:0];
    end
    case (mode)
      SCALE_MAJOR: begin
        step = ({4'd0, q} * 6'd12) + {2'd0, MAJOR_STEPS[rem]};
      end
      SCALE_MINOR: begin
        step = ({4'd0, q} * 6'd12) + {2'd0, MINOR_STEPS[rem]};
      end
      default: begin
        step = {1'b0, idx};
      end
    endcase
    return step;
  endfunction

  function automatic logic [6:0] clamp_note(input logic signed [9:0] v);
    logic [6:0] n;
    if (v < 10'sd0) begin
      n = 7'd0;
    end else if (v > NOTE_MAX) begin
      n = 7'd127;
    end else begin
      n = v[6:0];
    end
    return n;
  endfunction

endpackage

>>> sv/dcpm_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one MIDI event per beat into the chord pad mapper.
// Standalone; no package dependencies.
interface dcpm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] status_byte;
  logic [6:0] key_or_control;
  logic [6:0] velocity_or_value;
  logic [3:0] midi_channel;

  modport source (
    output valid, op, status_byte, key_or_control, velocity_or_value, midi_channel,
    input  ready
  );

  modport sink (
    input  valid, op, status_byte, key_or_control, velocity_or_value, midi_channel,
    output ready
  );
endinterface

>>> sv/dcpm_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one result per beat out of the chord pad mapper.
// Standalone; no package dependencies.
interface dcpm_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [6:0]        note_number;
  logic [6:0]        note_velocity;
  logic [3:0]        out_channel;
  logic signed [3:0] octave_now;
  logic              last;

  modport source (
    output valid, kind, note_number, note_velocity, out_channel, octave_now, last,
    input  ready
  );

  modport sink (
    input  valid, kind, note_number, note_velocity, out_channel, octave_now, last,
    output ready
  );
endinterface

>>> sv/diatonic_chord_pad_mapper_top.sv
// A pad note-on is turned into a three-note diatonic triad and any other event into a
// single beat; a pad event takes three output beats, one per cycle while the output keeps
// up, and every other event one beat. Single-beat events are accepted one per cycle while
// the output keeps up. An event waits in the input register and its results in the run
// buffer ahead of the single output register; the run buffer keeps the next event in the
// input register until the last result of the current run is loaded. Configuration is
// taken at any write-enable cycle and should only be written while no event is in flight.
`timescale 1ns / 1ps
// Top level of the diatonic chord pad mapper: configuration, mapping and output stages.
// Depends on dcpm_pkg, dcpm_in_if, dcpm_out_if, dcpm_cfg, dcpm_map and dcpm_emit.
module diatonic_chord_pad_mapper_top (
  input  logic                             clk,
  input  logic                             rst,
  dcpm_in_if.sink                          midi,
  dcpm_out_if.source                       chord,
  input  logic                             wr_en,
  input  logic [dcpm_pkg::REG_INDEX_W-1:0] wr_index,
  input  logic [dcpm_pkg::CFG_DATA_W-1:0]  wr_data
);
  import dcpm_pkg::*;

  cfg_t cfg;
  run_t run;
  logic run_valid;
  logic run_ready;

  dcpm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  dcpm_map u_map (
    .clk       (clk),
    .rst       (rst),
    .midi      (midi),
    .cfg       (cfg),
    .run       (run),
    .run_valid (run_valid),
    .run_ready (run_ready)
  );

  dcpm_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .chord     (chord)
  );

endmodule

>>> sv/dcpm_cfg.sv
`timescale 1ns / 1ps
// Chord pad mapper configuration registers; root, mode and octave writes saturate.
// Depends on dcpm_pkg.
module dcpm_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [dcpm_pkg::REG_INDEX_W-1:0]   wr_index,
  input  logic [dcpm_pkg::CFG_DATA_W-1:0]    wr_data,
  output dcpm_pkg::cfg_t                     cfg
);
  import dcpm_pkg::*;

  logic [3:0]        root_key;
  scale_t            scale_mode;
  logic [3:0]        second_interval;
  logic [3:0]        third_interval;
  logic signed [3:0] wr_signed;
  logic signed [3:0] oct_sat;

  assign wr_signed = signed'(wr_data);

  always_comb begin
    if (wr_signed > OCT_MAX) begin
      oct_sat = OCT_MAX;
    end else if (wr_signed < OCT_MIN) begin
      oct_sat = OCT_MIN;
    end else begin
      oct_sat = wr_signed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_key        <= 4'd0;
      scale_mode      <= SCALE_MAJOR;
      second_interval <= 4'd2;
      third_interval  <= 4'd4;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROOT_KEY: begin
          root_key <= (wr_data > ROOT_MAX) ? ROOT_MAX : wr_data;
        end
        REG_SCALE_MODE: begin
          scale_mode <= (wr_data[1:0] == SCALE_CHROMATIC || wr_data[1:0] == 2'd3) ?
                        SCALE_CHROMATIC : scale_t'(wr_data[1:0]);
        end
        REG_SECOND_INTERVAL: begin
          second_interval <= wr_data;
        end
        REG_THIRD_INTERVAL: begin
          third_interval <= wr_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.root_key        = root_key;
    cfg.scale_mode      = scale_mode;
    cfg.second_interval = second_interval;
    cfg.third_interval  = third_interval;
    cfg.oct_load        = wr_en && (wr_index == REG_START_OCTAVE);
    cfg.oct_value       = oct_sat;
  end

endmodule

>>> sv/dcpm_map.sv
`timescale 1ns / 1ps
// Input register, event decode, chord note computation and the kept octave.
// Depends on dcpm_pkg, dcpm_in_if and the cfg_t bundle from dcpm_cfg.
module dcpm_map (
  input  logic           clk,
  input  logic           rst,
  dcpm_in_if.sink        midi,
  input  dcpm_pkg::cfg_t cfg,
  output dcpm_pkg::run_t run,
  output logic           run_valid,
  input  logic           run_ready
);
  import dcpm_pkg::*;

  midi_item_t        item;
  logic              item_v;
  logic              accept;
  logic              advance;
  logic              is_pad;
  logic              is_btn;
  logic [4:0]        pad;
  logic [2:0]        pad_oct;
  logic [2:0]        degree;
  logic signed [9:0] oct_w;
  logic signed [9:0] base;
  logic [2:0][4:0]   idx;
  logic [2:0][6:0]   note;
  logic signed [3:0] octave_shift;
  logic signed [3:0] octave_step;

  assign accept    = midi.valid && midi.ready;
  assign advance   = item_v && run_ready;
  assign midi.ready = !item_v || run_ready;
  assign run_valid = item_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (accept) begin
      item_v <= 1'b1;
    end else if (advance) begin
      item_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op                <= midi.op;
      item.status_byte       <= midi.status_byte;
      item.key_or_control    <= midi.key_or_control;
      item.velocity_or_value <= midi.velocity_or_value;
      item.midi_channel      <= midi.midi_channel;
    end
  end

  assign is_pad = !item.op && (item.status_byte[7:4] == STATUS_NOTE_ON) &&
                  (item.velocity_or_value != 7'd0) &&
                  (item.key_or_control >= PAD_LOW) && (item.key_or_control <= PAD_HIGH);
  assign is_btn = item.op && (item.status_byte[7:4] == STATUS_CC) &&
                  (item.velocity_or_value != 7'd0) &&
                  (item.key_or_control == CC_OCT_UP || item.key_or_control == CC_OCT_DOWN);

  assign pad     = 5'(item.key_or_control - PAD_LOW);
  assign pad_oct = pad_div7(pad);
  assign degree  = 3'(pad - 5'({2'd0, pad_oct} * 3'd7));
  assign oct_w   = 10'(octave_shift);
  assign base    = MIDDLE_NOTE + oct_w * SEMIS_OCT + $signed({6'd0, cfg.root_key}) +
                   $signed({7'd0, pad_oct}) * SEMIS_OCT;

  assign idx[0] = {2'd0, degree};
  assign idx[1] = {2'd0, degree} + {1'b0, cfg.second_interval};
  assign idx[2] = {2'd0, degree} + {1'b0, cfg.third_interval};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      note[i] = clamp_note(base + $signed({4'd0, degree_semis(cfg.scale_mode, idx[i])}));
    end
  end

  always_comb begin
    if (item.key_or_control == CC_OCT_UP) begin
      octave_step = (octave_shift >= OCT_MAX) ? OCT_MAX : octave_shift + 4'sd1;
    end else begin
      octave_step = (octave_shift <= OCT_MIN) ? OCT_MIN : octave_shift - 4'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_shift <= 4'sd0;
    end else if (cfg.oct_load) begin
      octave_shift <= cfg.oct_value;
    end else if (advance && is_btn) begin
      octave_shift <= octave_step;
    end
  end

  always_comb begin
    run = '0;
    run.cnt = 2'd1;
    run.res[0].kind = KIND_IGNORED;
    run.res[0].octave_now = octave_shift;
    run.res[0].last = 1'b1;
    if (is_pad) begin
      run.cnt = 2'd3;
      for (int i = 0; i < 3; i++) begin
        run.res[i].kind          = KIND_NOTE;
        run.res[i].note_number   = note[i];
        run.res[i].note_velocity = item.velocity_or_value;
        run.res[i].out_channel   = item.midi_channel;
        run.res[i].octave_now    = octave_shift;
        run.res[i].last          = (i == 2);
      end
    end else if (is_btn) begin
      run.res[0].kind       = KIND_OCTAVE;
      run.res[0].octave_now = octave_step;
    end
  end

  kept_octave_in_range: assert property (@(posedge clk) disable iff (rst)
    octave_shift >= OCT_MIN && octave_shift <= OCT_MAX)
    else $error("Kept octave left its saturation range.");

  octave_load_applies: assert property (@(posedge clk) disable iff (rst)
    cfg.oct_load |=> octave_shift == $past(cfg.oct_value))
    else $error("Start octave write was not loaded into the kept octave.");

endmodule

>>> sv/dcpm_emit.sv
`timescale 1ns / 1ps
// Run buffer that holds the results of one event and plays them out, one per beat,
// through the output register. Depends on dcpm_pkg and dcpm_out_if.
module dcpm_emit (
  input  logic           clk,
  input  logic           rst,
  input  dcpm_pkg::run_t run,
  input  logic           run_valid,
  output logic           run_ready,
  dcpm_out_if.source     chord
);
  import dcpm_pkg::*;

  result_t [2:0] run_res;
  logic [1:0]    run_cnt;
  logic [1:0]    run_idx;
  logic          run_v;
  logic          load_out;
  logic          run_done;
  logic          take;
  logic          out_v;
  result_t       out_res;

  assign load_out  = run_v && (!out_v || chord.ready);
  assign run_done  = load_out && (run_idx == run_cnt - 2'd1);
  assign run_ready = !run_v || run_done;
  assign take      = run_valid && run_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_v   <= 1'b0;
      run_idx <= 2'd0;
    end else if (take) begin
      run_v   <= 1'b1;
      run_idx <= 2'd0;
    end else if (run_done) begin
      run_v <= 1'b0;
    end else if (load_out) begin
      run_idx <= run_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run_res <= run.res;
      run_cnt <= run.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (load_out) begin
      out_v <= 1'b1;
    end else if (chord.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res <= run_res[run_idx];
    end
  end

  assign chord.valid         = out_v;
  assign chord.kind          = out_res.kind;
  assign chord.note_number   = out_res.note_number;
  assign chord.note_velocity = out_res.note_velocity;
  assign chord.out_channel   = out_res.out_channel;
  assign chord.octave_now    = out_res.octave_now;
  assign chord.last          = out_res.last;

  run_index_bounded: assert property (@(posedge clk) disable iff (rst)
    run_v |-> run_idx < run_cnt)
    else $error("Run index passed the number of results held.");

  run_count_legal: assert property (@(posedge clk) disable iff (rst)
    run_v |-> (run_cnt == 2'd1 || run_cnt == 2'd3))
    else $error("Run holds a result count other than one or three.");

  run_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    run_done |-> run_res[run_idx].last)
    else $error("Run finished on a result without the last mark.");

endmodule

>>> sim/dcpm_chord_checker.sv
`timescale 1ns / 1ps
// Watches the event and chord channels of the chord pad mapper, predicts each chord beat and
// compares it with the beat that comes out. Depends on dcpm_pkg, dcpm_in_if and dcpm_out_if.
module dcpm_chord_checker
  import dcpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  dcpm_in_if                     midi,
  dcpm_out_if                    chord,
  input  logic                   wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output int                     beats_due,
  output int                     beat_errors
);

  localparam int IONIAN_OFS  [7] = '{0, 2, 4, 5, 7, 9, 11};
  localparam int AEOLIAN_OFS [7] = '{0, 2, 3, 5, 7, 8, 10};

  logic [3:0]        root_q;
  scale_t            mode_q;
  logic [3:0]        second_q;
  logic [3:0]        third_q;
  logic signed [3:0] oct_q;
  result_t           chord_due [$];

  function automatic int degree_step(input scale_t mode, input int idx);
    if (mode == SCALE_CHROMATIC) begin
      return idx;
    end
    if (mode == SCALE_MINOR) begin
      return (idx / 7) * 12 + AEOLIAN_OFS[idx % 7];
    end
    return (idx / 7) * 12 + IONIAN_OFS[idx % 7];
  endfunction

  function automatic logic [6:0] fit_note(input int v);
    if (v < 0) begin
      return 7'd0;
    end
    if (v > int'(NOTE_MAX)) begin
      return 7'd127;
    end
    return 7'(v);
  endfunction

  function automatic void map_event(input logic op, input logic [7:0] st, input logic [6:0] key,
                                    input logic [6:0] vel, input logic [3:0] ch);
    int      pad;
    int      base;
    int      offs [3];
    result_t beat;
    beat = '0;
    if (!op && st[7:4] == STATUS_NOTE_ON && vel != 7'd0 && key >= PAD_LOW && key <= PAD_HIGH) begin
      pad = int'(key - PAD_LOW);
      base = int'(MIDDLE_NOTE) + int'(SEMIS_OCT) * (int'(oct_q) + pad / 7) + int'(root_q);
      offs[0] = 0;
      offs[1] = int'(second_q);
      offs[2] = int'(third_q);
      for (int k = 0; k < 3; k++) begin
        beat.kind          = KIND_NOTE;
        beat.note_number   = fit_note(base + degree_step(mode_q, pad % 7 + offs[k]));
        beat.note_velocity = vel;
        beat.out_channel   = ch;
        beat.octave_now    = oct_q;
        beat.last          = (k == 2);
        chord_due.push_back(beat);
      end
    end else begin
      if (op && st[7:4] == STATUS_CC && vel != 7'd0 &&
          (key == CC_OCT_UP || key == CC_OCT_DOWN)) begin
        if (key == CC_OCT_UP && oct_q < OCT_MAX) begin
          oct_q = oct_q + 4'sd1;
        end else if (key == CC_OCT_DOWN && oct_q > OCT_MIN) begin
          oct_q = oct_q - 4'sd1;
        end
        beat.kind = KIND_OCTAVE;
      end else begin
        beat.kind = KIND_IGNORED;
      end
      beat.octave_now = oct_q;
      beat.last       = 1'b1;
      chord_due.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t           want;
    logic signed [3:0] start_v;
    logic              bad;
    if (rst) begin
      root_q      = 4'd0;
      mode_q      = SCALE_MAJOR;
      second_q    = 4'd2;
      third_q     = 4'd4;
      oct_q       = 4'sd0;
      beat_errors = 0;
      chord_due.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_ROOT_KEY: begin
            root_q = (wr_data > ROOT_MAX) ? ROOT_MAX : wr_data;
          end
          REG_SCALE_MODE: begin
            mode_q = (wr_data[1:0] > SCALE_CHROMATIC) ? SCALE_CHROMATIC : scale_t'(wr_data[1:0]);
          end
          REG_SECOND_INTERVAL: begin
            second_q = wr_data;
          end
          REG_THIRD_INTERVAL: begin
            third_q = wr_data;
          end
          REG_START_OCTAVE: begin
            start_v = signed'(wr_data);
            if (start_v < OCT_MIN) begin
              oct_q = OCT_MIN;
            end else if (start_v > OCT_MAX) begin
              oct_q = OCT_MAX;
            end else begin
              oct_q = start_v;
            end
          end
          default: begin
          end
        endcase
      end
      if (midi.valid && midi.ready) begin
        map_event(midi.op, midi.status_byte, midi.key_or_control, midi.velocity_or_value,
                  midi.midi_channel);
      end
      if (chord.valid && chord.ready) begin
        if (chord_due.size() == 0) begin
          if (beat_errors < 10) begin
            $display("chord beat with nothing due: kind %0d note %0d vel %0d ch %0d oct %0d last %0b",
                     chord.kind, chord.note_number, chord.note_velocity, chord.out_channel,
                     chord.octave_now, chord.last);
          end
          beat_errors++;
        end else begin
          want = chord_due.pop_front();
          bad = (chord.kind !== want.kind) || (chord.note_number !== want.note_number) ||
                (chord.note_velocity !== want.note_velocity) ||
                (chord.out_channel !== want.out_channel) ||
                (chord.octave_now !== want.octave_now) || (chord.last !== want.last);
          if (bad) begin
            if (beat_errors < 10) begin
              $display("chord beat mismatch: expected kind %0d note %0d vel %0d ch %0d oct %0d last %0b",
                       want.kind, want.note_number, want.note_velocity, want.out_channel,
                       want.octave_now, want.last);
              $display("                       actual kind %0d note %0d vel %0d ch %0d oct %0d last %0b",
                       chord.kind, chord.note_number, chord.note_velocity, chord.out_channel,
                       chord.octave_now, chord.last);
            end
            beat_errors++;
          end
        end
      end
    end
    beats_due = chord_due.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the chord pad mapper test: clock, reset, register writes, event and back-pressure
// stimulus, watchdog and verdict. Depends on dcpm_pkg, both channel interfaces and the checker.
module testbench;
  import dcpm_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASES        = 8;
  localparam int PHASE_EVENTS  = 26;

  localparam logic [3:0]             STATUS_NOTE_OFF = 4'h8;
  localparam logic [CFG_DATA_W-1:0]  SCALE_BEYOND    = 4'd3;
  localparam logic [REG_INDEX_W-1:0] REG_UNUSED_LO   = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_UNUSED_HI   = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [REG_INDEX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0]  wr_data = '0;
  logic squeeze = 1'b0;
  logic squeeze_done = 1'b0;
  logic sender_burst = 1'b0;
  int   beats_due;
  int   beat_errors;

  always #5 clk = ~clk;

  dcpm_in_if  midi ();
  dcpm_out_if chord ();

  diatonic_chord_pad_mapper_top DUT (
    .clk      (clk),
    .rst      (rst),
    .midi     (midi),
    .chord    (chord),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  dcpm_chord_checker chord_check (
    .clk         (clk),
    .rst         (rst),
    .midi        (midi),
    .chord       (chord),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .beats_due   (beats_due),
    .beat_errors (beat_errors)
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(15, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  task automatic send_event(input logic op, input logic [7:0] st, input logic [6:0] key,
                            input logic [6:0] vel, input logic [3:0] ch);
    int gap;
    gap = 0;
    if (!sender_burst && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    @(negedge clk);
    if (gap > 0) begin
      midi.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    midi.op                = op;
    midi.status_byte       = st;
    midi.key_or_control    = key;
    midi.velocity_or_value = vel;
    midi.midi_channel      = ch;
    midi.valid             = 1'b1;
    do @(posedge clk); while (!midi.ready);
  endtask

  // Mostly pads and octave buttons with random content, then near misses and raw noise.
  task automatic send_random_event(output logic counted);
    int         pick;
    logic       op;
    logic [7:0] st;
    logic [6:0] key;
    logic [6:0] vel;
    pick = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 50) begin
      op  = 1'b0;
      st  = {STATUS_NOTE_ON, 4'($urandom)};
      key = PAD_LOW + 7'($urandom_range(0, 31));
      vel = 7'($urandom_range(1, 127));
    end else if (pick < 72) begin
      op  = 1'b1;
      st  = {STATUS_CC, 4'($urandom)};
      key = $urandom_range(0, 1) ? CC_OCT_UP : CC_OCT_DOWN;
      vel = 7'($urandom_range(1, 127));
    end else begin
      counted = 1'b0;
      op  = 1'($urandom);
      st  = 8'($urandom);
      key = 7'($urandom);
      vel = 7'($urandom);
      if (pick < 84) begin
        if (op) begin
          st  = {STATUS_CC, 4'($urandom)};
          key = $urandom_range(0, 1) ? CC_OCT_UP : CC_OCT_DOWN;
        end else begin
          st  = {STATUS_NOTE_ON, 4'($urandom)};
          key = $urandom_range(0, 1) ? PAD_LOW + 7'($urandom_range(0, 31))
                                     : ($urandom_range(0, 1) ? PAD_LOW - 7'd1 : PAD_HIGH + 7'd1);
        end
        if ($urandom_range(0, 1)) begin
          vel = 7'd0;
        end else if ($urandom_range(0, 1)) begin
          op = ~op;
        end
      end
    end
    send_event(op, st, key, vel, 4'($urandom_range(0, 15)));
  endtask

  task automatic drain();
    @(negedge clk);
    midi.valid = 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic load_settings(input logic [3:0] root, input logic [3:0] scale,
                               input logic [3:0] second, input logic [3:0] third,
                               input logic [3:0] start);
    drain();
    write_reg(REG_ROOT_KEY, root);
    write_reg(REG_SCALE_MODE, scale);
    write_reg(REG_SECOND_INTERVAL, second);
    write_reg(REG_THIRD_INTERVAL, third);
    write_reg(REG_START_OCTAVE, start);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_UNUSED_LO + 3'($urandom_range(0, 2)), 4'($urandom));
    end
  endtask

  initial begin : ready_ctl
    int gap;
    int calm;
    gap = 0;
    calm = 0;
    chord.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !squeeze_done) begin
        chord.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        squeeze_done = 1'b1;
      end else if (gap > 0) begin
        chord.ready = 1'b0;
        gap--;
      end else begin
        chord.ready = 1'b1;
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 99) < 3) begin
          calm = $urandom_range(30, 120);
        end else if ($urandom_range(0, 3) == 0) begin
          gap = pick_gap();
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((midi.valid && midi.ready) || (chord.valid && chord.ready) || wr_en) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic counted;
    int   done;
    midi.valid             = 1'b0;
    midi.op                = 1'b0;
    midi.status_byte       = '0;
    midi.key_or_control    = '0;
    midi.velocity_or_value = '0;
    midi.midi_channel      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default settings: pad range edges, near misses and single octave steps.
    send_event(1'b0, {STATUS_NOTE_ON, 4'h0}, PAD_LOW, 7'd1, 4'd0);
    send_event(1'b0, {STATUS_NOTE_ON, 4'hF}, PAD_HIGH, 7'd127, 4'd15);
    send_event(1'b0, {STATUS_NOTE_ON, 4'h3}, PAD_LOW - 7'd1, 7'd64, 4'd3);
    send_event(1'b0, {STATUS_NOTE_ON, 4'h3}, PAD_HIGH + 7'd1, 7'd64, 4'd3);
    send_event(1'b0, {STATUS_NOTE_ON, 4'h5}, PAD_LOW + 7'd10, 7'd0, 4'd5);
    send_event(1'b0, {STATUS_NOTE_OFF, 4'h5}, PAD_LOW + 7'd10, 7'd90, 4'd5);
    send_event(1'b1, {STATUS_NOTE_ON, 4'h1}, PAD_LOW + 7'd3, 7'd90, 4'd1);
    send_event(1'b0, {STATUS_CC, 4'h2}, CC_OCT_UP, 7'd90, 4'd2);
    send_event(1'b1, {STATUS_CC, 4'hF}, CC_OCT_UP, 7'd127, 4'd9);
    send_event(1'b1, {STATUS_CC, 4'h0}, CC_OCT_DOWN, 7'd1, 4'd9);
    send_event(1'b1, {STATUS_CC, 4'h0}, CC_OCT_DOWN, 7'd0, 4'd9);
    send_event(1'b1, {STATUS_CC, 4'h0}, CC_OCT_UP + 7'd1, 7'd5, 4'd9);
    send_event(1'b1, {STATUS_CC, 4'h0}, CC_OCT_DOWN - 7'd1, 7'd5, 4'd9);

    // Out-of-range writes saturate; the octave sits at its top and notes clip at the top.
    load_settings(4'd15, SCALE_BEYOND, 4'd15, 4'd15, 4'sd7);
    write_reg(REG_UNUSED_LO, 4'd9);
    write_reg(REG_UNUSED_HI, 4'd15);
    send_event(1'b1, {STATUS_CC, 4'h7}, CC_OCT_UP, 7'd100, 4'd7);
    send_event(1'b0, {STATUS_NOTE_ON, 4'hA}, PAD_HIGH, 7'd64, 4'd10);
    send_event(1'b0, {STATUS_NOTE_ON, 4'hA}, PAD_LOW, 7'd64, 4'd10);

    load_settings(4'd0, SCALE_MINOR, 4'd0, 4'd0, 4'b1000);
    send_event(1'b1, {STATUS_CC, 4'h4}, CC_OCT_DOWN, 7'd33, 4'd4);
    send_event(1'b0, {STATUS_NOTE_ON, 4'h4}, PAD_LOW, 7'd33, 4'd4);
    send_event(1'b0, {STATUS_NOTE_ON, 4'h4}, PAD_LOW + 7'd22, 7'd85, 4'd6);

    load_settings(ROOT_MAX, SCALE_MAJOR, 4'd15, 4'd1, -4'sd5);
    send_event(1'b0, {STATUS_NOTE_ON, 4'hC}, PAD_HIGH, 7'd42, 4'd12);
    send_event(1'b0, {STATUS_NOTE_ON, 4'hC}, PAD_LOW + 7'd6, 7'd42, 4'd12);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          load_settings(4'd0, SCALE_MAJOR, 4'd0, 4'd0, 4'sd0);
        end
        1: begin
          load_settings(ROOT_MAX, SCALE_CHROMATIC, 4'd15, 4'd15, 4'sd5);
        end
        2: begin
          load_settings(4'd7, SCALE_MINOR, 4'd2, 4'd4, -4'sd5);
        end
        default: begin
          load_settings(4'($urandom_range(0, 15)), 4'($urandom_range(0, 3)), 4'($urandom),
                        4'($urandom), 4'($urandom));
        end
      endcase
      sender_burst = (phase == 2 || phase == 6);
      if (phase == 3) begin
        squeeze = 1'b1;
      end
      done = 0;
      while (done < PHASE_EVENTS) begin
        send_random_event(counted);
        if (counted) begin
          done++;
        end
        if (phase == 5 && counted && done == PHASE_EVENTS / 2) begin
          drain();
        end
      end
    end

    drain();
    if (beat_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
